[src/binary_fixed_to_decimal_ascii_top_defines.svh]
// Assertion macros for the fixed-point to decimal ASCII converter.
// No dependencies; included by the checker module.
`ifndef BINARY_FIXED_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define BINARY_FIXED_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// same-cycle implication
`define BFDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/bfda_pkg.sv]
// Shared types and constants for the fixed-point to decimal ASCII converter.
// No dependencies.
package bfda_pkg;

  localparam int unsigned NUM_CHARS = 6;

  localparam logic [31:0] VALUE_LIMIT = 32'd256000;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_BLANK = 8'h20;

  typedef logic [7:0] char_t;
  typedef char_t [NUM_CHARS-1:0] text_t;

  // handshake between the digit pipeline and the serializer
  typedef struct packed {
    logic valid;
  } hs_t;

endpackage

[src/bfda_digits.sv]
// Three-stage digit pipeline: range check, digit split, character build.
// Depends on bfda_pkg.
module bfda_digits (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_value,
  output bfda_pkg::hs_t        hs_o,
  input  logic                 hs_ready_i,
  output bfda_pkg::text_t      text_o
);
  import bfda_pkg::*;

  // stage 1
  logic        s1_v_r;
  logic        s1_over_r;
  logic [9:0]  s1_ip_r;
  logic [7:0]  s1_frac_r;
  // stage 2
  logic        s2_v_r;
  logic        s2_over_r;
  logic [3:0]  s2_d2_r;
  logic [6:0]  s2_rem_r;
  logic [6:0]  s2_hund_r;
  // stage 3
  logic        s3_v_r;
  text_t       s3_text_r;

  logic        s1_rdy, s2_rdy, s3_rdy;

  logic [15:0] ip_x41;
  logic [3:0]  d2_nxt;
  logic [9:0]  d2_x100;
  logic [6:0]  rem_nxt;
  logic [14:0] frac_x100;
  logic [6:0]  hund_nxt;

  logic [14:0] rem_x205;
  logic [3:0]  d1;
  logic [3:0]  d0;
  logic [14:0] hund_x205;
  logic [3:0]  h1;
  logic [3:0]  h0;
  text_t       text_nxt;

  assign s3_rdy   = !s3_v_r || hs_ready_i;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_stall = !s1_rdy;

  // x/100 = (x*41)>>12 for x < 1000
  assign ip_x41    = 16'(s1_ip_r) * 16'd41;
  assign d2_nxt    = ip_x41[15:12];
  assign d2_x100   = 10'(d2_nxt) * 10'd100;
  assign rem_nxt   = 7'(s1_ip_r - d2_x100);
  assign frac_x100 = 15'(s1_frac_r) * 15'd100;
  assign hund_nxt  = frac_x100[14:8];

  // x/10 = (x*205)>>11 for x < 100
  assign rem_x205  = 15'(s2_rem_r) * 15'd205;
  assign d1        = rem_x205[14:11];
  assign d0        = 4'(s2_rem_r - 7'(d1) * 7'd10);
  assign hund_x205 = 15'(s2_hund_r) * 15'd205;
  assign h1        = hund_x205[14:11];
  assign h0        = 4'(s2_hund_r - 7'(h1) * 7'd10);

  always_comb begin
    if (s2_over_r) begin
      text_nxt = {CH_STAR, CH_STAR, CH_STAR, CH_DOT, CH_STAR, CH_STAR};
    end else begin
      text_nxt[5] = (s2_d2_r == 4'd0) ? CH_BLANK : CH_ZERO + 8'(s2_d2_r);
      text_nxt[4] = (s2_d2_r == 4'd0 && d1 == 4'd0) ? CH_BLANK : CH_ZERO + 8'(d1);
      text_nxt[3] = CH_ZERO + 8'(d0);
      text_nxt[2] = CH_DOT;
      text_nxt[1] = CH_ZERO + 8'(h1);
      text_nxt[0] = CH_ZERO + 8'(h0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_over_r <= (in_value >= VALUE_LIMIT);
      s1_ip_r   <= in_value[17:8];
      s1_frac_r <= in_value[7:0];
    end
    if (s2_rdy && s1_v_r) begin
      s2_over_r <= s1_over_r;
      s2_d2_r   <= d2_nxt;
      s2_rem_r  <= rem_nxt;
      s2_hund_r <= hund_nxt;
    end
    if (s3_rdy && s2_v_r) begin
      s3_text_r <= text_nxt;
    end
  end

  always_comb begin
    hs_o.valid = s3_v_r;
  end
  assign text_o = s3_text_r;

endmodule

[src/bfda_serial.sv]
// Character serializer: shifts out the six characters of one value.
// Depends on bfda_pkg.
module bfda_serial (
  input  logic             clk,
  input  logic             rst_n,
  input  bfda_pkg::hs_t    hs_i,
  output logic             ready_o,
  input  bfda_pkg::text_t  text_i,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_character,
  output logic             out_last
);
  import bfda_pkg::*;

  localparam logic [2:0] LAST_IDX = 3'(NUM_CHARS - 1);

  logic       v_r;
  logic [2:0] cnt_r;
  text_t      text_r;
  logic       xfer;
  logic       done;
  logic       load;

  assign xfer    = v_r && !out_stall;
  assign done    = xfer && (cnt_r == LAST_IDX);
  assign ready_o = !v_r || done;
  assign load    = ready_o && hs_i.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      cnt_r <= 3'd0;
    end else if (ready_o) begin
      v_r   <= hs_i.valid;
      cnt_r <= 3'd0;
    end else if (xfer) begin
      cnt_r <= cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      text_r <= text_i;
    end else if (xfer) begin
      text_r <= {text_r[NUM_CHARS-2:0], CH_BLANK};
    end
  end

  assign out_valid     = v_r;
  assign out_character = text_r[NUM_CHARS-1];
  assign out_last      = (cnt_r == LAST_IDX);

endmodule

[src/binary_fixed_to_decimal_ascii_top.sv]
// Converts an unsigned Q24.8 value to six ASCII characters "ddd.dd" (hundredths
// truncated, leading integer zeros blank, "***.**" at 256000 and above). The
// characters of one value leave one at a time through the single character
// port; each value passes the three digit stages and then the serializer
// register before its first character reaches the output. The next value is
// taken while the current one is still shifting out.
// Depends on bfda_pkg, bfda_digits, bfda_serial.
module binary_fixed_to_decimal_ascii_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_character,
  output logic        out_last
);
  import bfda_pkg::*;

  hs_t   dig_hs;
  logic  ser_ready;
  text_t dig_text;

  bfda_digits u_digits (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .hs_o       (dig_hs),
    .hs_ready_i (ser_ready),
    .text_o     (dig_text)
  );

  bfda_serial u_serial (
    .clk           (clk),
    .rst_n         (rst_n),
    .hs_i          (dig_hs),
    .ready_o       (ser_ready),
    .text_i        (dig_text),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

[src/bfda_checker.sv]
// Port-level checker for binary_fixed_to_decimal_ascii_top, bound to it.
// Depends on bfda_pkg and binary_fixed_to_decimal_ascii_top_defines.svh.
`include "binary_fixed_to_decimal_ascii_top_defines.svh"

module bfda_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_character,
  input logic        out_last
);
  import bfda_pkg::*;

  localparam logic [2:0] LAST_POS = 3'(NUM_CHARS - 1);
  localparam logic [2:0] DOT_POS  = 3'd3;

  logic [2:0] pos_r;
  logic       out_xfer;
  logic       out_busy;
  logic [8:0] out_word;
  logic       char_ok;

  assign out_xfer = out_valid && !out_stall;
  assign out_busy = out_valid && out_stall;
  assign out_word = {out_character, out_last};
  assign char_ok  = (out_character == CH_BLANK) || (out_character == CH_STAR) ||
                    (out_character == CH_DOT) ||
                    (out_character >= CH_ZERO && out_character <= CH_ZERO + 8'd9);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 3'd0;
    end else if (out_xfer) begin
      pos_r <= (pos_r == LAST_POS) ? 3'd0 : pos_r + 3'd1;
    end
  end

  `BFDA_ASSERT_NEXT(a_out_hold, out_busy, out_valid && $stable(out_word), "output moved")
  `BFDA_ASSERT_NOW(a_last_pos, out_valid, out_last == (pos_r == LAST_POS), "last misplaced")
  `BFDA_ASSERT_NOW(a_dot_pos, out_valid && pos_r == DOT_POS, out_character == CH_DOT, "dot misplaced")
  `BFDA_ASSERT_NOW(a_char_set, out_valid, char_ok, "illegal character")
  `BFDA_ASSERT_NOW(a_stall_busy, in_stall, out_valid, "input stalled while output idle")

endmodule

bind binary_fixed_to_decimal_ascii_top bfda_checker u_bfda_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_character (out_character),
  .out_last      (out_last)
);
